/* hw/rtl/brc_pkg.sv */
// shared types, widths and constants for the barometer reading compensation core
package brc_pkg;

    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int TEMP_W  = 19;  // first-order temperature, centi-degrees
    localparam int TCOR_W  = 20;  // second-order corrected temperature
    localparam int OFF_W   = 36;  // first-order offset
    localparam int SENS_W  = 35;  // first-order sensitivity
    localparam int OFFC_W  = 40;  // corrected offset
    localparam int SENSC_W = 39;  // corrected sensitivity
    localparam int T2LO_W  = 17;
    localparam int T2HI_W  = 13;
    localparam int SQ_W    = 36;

    localparam int TOUT_W  = 15;
    localparam int POUT_W  = 17;

    localparam logic signed [TEMP_W-1:0] TEMP_REF       = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_VERY_LOW  = -19'sd1500;

    localparam logic signed [TCOR_W-1:0] TEMP_MIN_CENTI = -20'sd4000;
    localparam logic signed [TCOR_W-1:0] TEMP_MAX_CENTI = 20'sd8500;
    localparam logic signed [28:0]       PRES_MIN_CENTI = 29'sd1000;
    localparam logic signed [28:0]       PRES_MAX_CENTI = 29'sd120000;

    typedef enum logic [2:0] {
        CFG_C1 = 3'd0,
        CFG_C2 = 3'd1,
        CFG_C3 = 3'd2,
        CFG_C4 = 3'd3,
        CFG_C5 = 3'd4,
        CFG_C6 = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [COEF_W-1:0] c1;
        logic [COEF_W-1:0] c2;
        logic [COEF_W-1:0] c3;
        logic [COEF_W-1:0] c4;
        logic [COEF_W-1:0] c5;
        logic [COEF_W-1:0] c6;
    } cal_t;

    typedef struct packed {
        logic [RAW_W-1:0]          d1;
        logic signed [TEMP_W-1:0]  temp;
        logic signed [OFF_W-1:0]   off;
        logic signed [SENS_W-1:0]  sens;
        logic [T2LO_W-1:0]         t2lo;
        logic [T2HI_W-1:0]         t2hi;
    } first_t;

    typedef struct packed {
        logic [RAW_W-1:0]           d1;
        logic signed [TCOR_W-1:0]   tcorr;
        logic signed [OFFC_W-1:0]   off_c;
        logic signed [SENSC_W-1:0]  sens_c;
    } second_t;

endpackage

/* hw/rtl/brc_first.sv */
// first-order stages: temperature difference, products, temp/offset/sensitivity, t2 terms
module brc_first (
    input  logic                              clk,
    input  logic                              rst_n,
    input  brc_pkg::cal_t                     cal,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [brc_pkg::RAW_W-1:0]         raw_pressure,
    input  logic [brc_pkg::RAW_W-1:0]         raw_temperature,
    output logic                              out_valid,
    input  logic                              out_ready,
    output brc_pkg::first_t                   out_word
);

    logic vld_a_reg, vld_b_reg, vld_c_reg;
    logic en_a, en_b, en_c;

    // stage a
    logic [brc_pkg::RAW_W-1:0]  d1_a_reg;
    logic signed [24:0]         dt_a_reg;
    logic signed [24:0]         dt_next;

    // stage b
    logic [brc_pkg::RAW_W-1:0]  d1_b_reg;
    logic signed [41:0]         mt_b_reg, mo_b_reg, ms_b_reg;
    logic signed [41:0]         mt_next, mo_next, ms_next;
    logic [48:0]                mdd_b_reg;
    logic signed [49:0]         mdd_full;

    // stage c
    brc_pkg::first_t            out_c_reg;
    brc_pkg::first_t            out_next;
    logic signed [41:0]         mt_sh, mo_sh, ms_sh;
    logic [50:0]                mdd3, mdd5;

    assign en_c     = ~vld_c_reg | out_ready;
    assign en_b     = ~vld_b_reg | en_c;
    assign en_a     = ~vld_a_reg | en_b;
    assign in_ready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                vld_a_reg <= in_valid;
            if (en_b)
                vld_b_reg <= vld_a_reg;
            if (en_c)
                vld_c_reg <= vld_b_reg;
        end
    end

    assign dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'h00});

    assign mt_next  = dt_a_reg * $signed({1'b0, cal.c6});
    assign mo_next  = dt_a_reg * $signed({1'b0, cal.c4});
    assign ms_next  = dt_a_reg * $signed({1'b0, cal.c3});
    assign mdd_full = dt_a_reg * dt_a_reg;

    assign mt_sh = mt_b_reg >>> 23;
    assign mo_sh = mo_b_reg >>> 6;
    assign ms_sh = ms_b_reg >>> 7;
    assign mdd3  = {1'b0, mdd_b_reg, 1'b0} + {2'b00, mdd_b_reg};
    assign mdd5  = {mdd_b_reg, 2'b00} + {2'b00, mdd_b_reg};

    always_comb
    begin
        out_next.d1   = d1_b_reg;
        out_next.temp = brc_pkg::TEMP_REF + $signed(mt_sh[brc_pkg::TEMP_W-1:0]);
        out_next.off  = $signed({3'b000, cal.c2, 17'h00000})
                      + $signed(mo_sh[brc_pkg::OFF_W-1:0]);
        out_next.sens = $signed({3'b000, cal.c1, 16'h0000})
                      + $signed(ms_sh[brc_pkg::SENS_W-1:0]);
        out_next.t2lo = mdd3[49:33];
        out_next.t2hi = mdd5[50:38];
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            d1_a_reg <= raw_pressure;
            dt_a_reg <= dt_next;
        end
        if (en_b)
        begin
            d1_b_reg  <= d1_a_reg;
            mt_b_reg  <= mt_next;
            mo_b_reg  <= mo_next;
            ms_b_reg  <= ms_next;
            mdd_b_reg <= mdd_full[48:0];
        end
        if (en_c)
            out_c_reg <= out_next;
    end

    assign out_valid = vld_c_reg;
    assign out_word  = out_c_reg;

endmodule

/* hw/rtl/brc_second.sv */
// second-order stages: low / very-low / high temperature corrections
module brc_second (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  brc_pkg::first_t   in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output brc_pkg::second_t  out_word
);

    logic vld_d_reg, vld_e_reg;
    logic en_d, en_e;

    // stage d
    logic [brc_pkg::RAW_W-1:0]          d1_d_reg;
    logic signed [brc_pkg::OFF_W-1:0]   off_d_reg;
    logic signed [brc_pkg::SENS_W-1:0]  sens_d_reg;
    logic signed [brc_pkg::TCOR_W-1:0]  tcorr_d_reg, tcorr_next;
    logic [brc_pkg::SQ_W-1:0]           sq_d_reg, sq2_d_reg;
    logic                               low_d_reg, vlow_d_reg, low_next, vlow_next;
    logic signed [brc_pkg::TCOR_W-1:0]  temp_ext, dlow, dvl;
    logic signed [39:0]                 sq_full, sq2_full;
    logic [brc_pkg::TCOR_W-1:0]         t2_sel;

    // stage e
    brc_pkg::second_t                   out_e_reg, out_next;
    logic [41:0]                        off2_lo, off2_vl, off2;
    logic [40:0]                        sens2_lo, sens2_vl, sens2;
    logic signed [43:0]                 off_diff;
    logic signed [42:0]                 sens_diff;

    assign en_e     = ~vld_e_reg | out_ready;
    assign en_d     = ~vld_d_reg | en_e;
    assign in_ready = en_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
        end
        else
        begin
            if (en_d)
                vld_d_reg <= in_valid;
            if (en_e)
                vld_e_reg <= vld_d_reg;
        end
    end

    assign temp_ext  = {in_word.temp[brc_pkg::TEMP_W-1], in_word.temp};
    assign dlow      = temp_ext - 20'sd2000;
    assign dvl       = temp_ext + 20'sd1500;
    assign sq_full   = dlow * dlow;
    assign sq2_full  = dvl * dvl;
    assign low_next  = in_word.temp < brc_pkg::TEMP_REF;
    assign vlow_next = in_word.temp < brc_pkg::TEMP_VERY_LOW;
    assign t2_sel    = low_next ? {3'b000, in_word.t2lo} : {7'h00, in_word.t2hi};
    assign tcorr_next = temp_ext - $signed(t2_sel);

    // constant multiplies reduce to shift-add
    assign off2_lo  = ({6'h00, sq_d_reg} * 42'd61) >> 4;
    assign off2_vl  = {6'h00, sq2_d_reg} * 42'd17;
    assign sens2_lo = ({5'h00, sq_d_reg} * 41'd29) >> 4;
    assign sens2_vl = {5'h00, sq2_d_reg} * 41'd9;

    always_comb
    begin
        off2  = '0;
        sens2 = '0;
        if (low_d_reg)
        begin
            off2  = off2_lo;
            sens2 = sens2_lo;
            if (vlow_d_reg)
            begin
                off2  = off2_lo + off2_vl;
                sens2 = sens2_lo + sens2_vl;
            end
        end
        off_diff  = $signed({{8{off_d_reg[brc_pkg::OFF_W-1]}}, off_d_reg})
                  - $signed({2'b00, off2});
        sens_diff = $signed({{8{sens_d_reg[brc_pkg::SENS_W-1]}}, sens_d_reg})
                  - $signed({2'b00, sens2});
        out_next.d1     = d1_d_reg;
        out_next.tcorr  = tcorr_d_reg;
        out_next.off_c  = off_diff[brc_pkg::OFFC_W-1:0];
        out_next.sens_c = sens_diff[brc_pkg::SENSC_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_d)
        begin
            d1_d_reg    <= in_word.d1;
            off_d_reg   <= in_word.off;
            sens_d_reg  <= in_word.sens;
            tcorr_d_reg <= tcorr_next;
            sq_d_reg    <= sq_full[brc_pkg::SQ_W-1:0];
            sq2_d_reg   <= sq2_full[brc_pkg::SQ_W-1:0];
            low_d_reg   <= low_next;
            vlow_d_reg  <= vlow_next;
        end
        if (en_e)
            out_e_reg <= out_next;
    end

    assign out_valid = vld_e_reg;
    assign out_word  = out_e_reg;

endmodule

/* hw/rtl/brc_pres.sv */
// pressure stages: split product, offset subtract, saturation and output register
module brc_pres (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  brc_pkg::second_t                   in_word,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [brc_pkg::TOUT_W-1:0]  temperature_centi,
    output logic [brc_pkg::POUT_W-1:0]         pressure_centi_mbar,
    output logic                               out_of_range
);

    logic vld_f_reg, vld_g_reg, vld_h_reg;
    logic en_f, en_g, en_h;

    // stage f: two partial products of d1 * sens
    logic [43:0]                         pl_f_reg, pl_next;
    logic signed [43:0]                  ph_f_reg, ph_next;
    logic signed [brc_pkg::TCOR_W-1:0]   tcorr_f_reg, tcorr_g_reg;
    logic signed [brc_pkg::OFFC_W-1:0]   off_f_reg, off_g_reg;

    // stage g
    logic signed [63:0]                  prod;
    logic signed [63:0]                  prod_sh;
    logic signed [42:0]                  psh_g_reg;

    // stage h
    logic signed [43:0]                  x;
    logic signed [43:0]                  x_sh;
    logic signed [28:0]                  p;
    logic signed [brc_pkg::TCOR_W-1:0]   t_sat;
    logic signed [28:0]                  p_sat;
    logic                                t_clamp, p_clamp;
    logic signed [brc_pkg::TOUT_W-1:0]   tout_h_reg;
    logic [brc_pkg::POUT_W-1:0]          pout_h_reg;
    logic                                oor_h_reg;

    assign en_h     = ~vld_h_reg | out_ready;
    assign en_g     = ~vld_g_reg | en_h;
    assign en_f     = ~vld_f_reg | en_g;
    assign in_ready = en_f;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_f_reg <= 1'b0;
            vld_g_reg <= 1'b0;
            vld_h_reg <= 1'b0;
        end
        else
        begin
            if (en_f)
                vld_f_reg <= in_valid;
            if (en_g)
                vld_g_reg <= vld_f_reg;
            if (en_h)
                vld_h_reg <= vld_g_reg;
        end
    end

    // low 20 bits unsigned, upper 19 bits carry the sign
    assign pl_next = {20'h00000, in_word.d1} * {24'h000000, in_word.sens_c[19:0]};
    assign ph_next = $signed({1'b0, in_word.d1}) * $signed(in_word.sens_c[38:20]);

    assign prod    = $signed({ph_f_reg, 20'h00000}) + $signed({20'h00000, pl_f_reg});
    assign prod_sh = prod >>> 21;

    assign x    = $signed({psh_g_reg[42], psh_g_reg})
                - $signed({{4{off_g_reg[brc_pkg::OFFC_W-1]}}, off_g_reg});
    assign x_sh = x >>> 15;
    assign p    = x_sh[28:0];

    always_comb
    begin
        t_sat   = tcorr_g_reg;
        t_clamp = 1'b0;
        if (tcorr_g_reg < brc_pkg::TEMP_MIN_CENTI)
        begin
            t_sat   = brc_pkg::TEMP_MIN_CENTI;
            t_clamp = 1'b1;
        end
        else if (tcorr_g_reg > brc_pkg::TEMP_MAX_CENTI)
        begin
            t_sat   = brc_pkg::TEMP_MAX_CENTI;
            t_clamp = 1'b1;
        end
        p_sat   = p;
        p_clamp = 1'b0;
        if (p < brc_pkg::PRES_MIN_CENTI)
        begin
            p_sat   = brc_pkg::PRES_MIN_CENTI;
            p_clamp = 1'b1;
        end
        else if (p > brc_pkg::PRES_MAX_CENTI)
        begin
            p_sat   = brc_pkg::PRES_MAX_CENTI;
            p_clamp = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            pl_f_reg    <= pl_next;
            ph_f_reg    <= ph_next;
            tcorr_f_reg <= in_word.tcorr;
            off_f_reg   <= in_word.off_c;
        end
        if (en_g)
        begin
            psh_g_reg   <= prod_sh[42:0];
            tcorr_g_reg <= tcorr_f_reg;
            off_g_reg   <= off_f_reg;
        end
        if (en_h)
        begin
            tout_h_reg <= t_sat[brc_pkg::TOUT_W-1:0];
            pout_h_reg <= p_sat[brc_pkg::POUT_W-1:0];
            oor_h_reg  <= t_clamp | p_clamp;
        end
    end

    assign out_valid           = vld_h_reg;
    assign temperature_centi   = tout_h_reg;
    assign pressure_centi_mbar = pout_h_reg;
    assign out_of_range        = oor_h_reg;

endmodule

/* hw/rtl/barometer_reading_compensation_core.sv */
// top level: calibration registers, stream ports and the eight-stage compensation pipeline
//
//  channel  | signals                          | word
//  ---------+----------------------------------+----------------------------------------
//  input    | s_tvalid s_tready s_tdata[47:0]  | raw_pressure, raw_temperature
//  output   | m_tvalid m_tready m_tdata[31:0]  | temperature_centi, pressure_centi_mbar
//           | m_tuser[0]                       | out_of_range
//  config   | cfg_we cfg_index[2:0] cfg_data   | six 16-bit calibration words
//
//  one word per cycle sustained while m_tready stays high; registered stages from input accept to m_tvalid
//  (dt, products, first order, squares, corrections, split pressure product, sum, clamp)
//  each stage holds its own valid bit and loads whenever it is empty or the next one moves,
//  so bubbles close up and s_tready drops only when every stage is full and m_tready is low
//  rst_n clears the valid bits and the calibration words to zero
module barometer_reading_compensation_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // raw_pressure[23:0], raw_temperature[47:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // temperature_centi[14:0], pressure_centi_mbar[31:15]
    output logic [0:0]  m_tuser,   // out_of_range[0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    brc_pkg::cal_t     cal_reg;
    brc_pkg::first_t   first_word;
    brc_pkg::second_t  second_word;
    logic              first_valid, first_ready;
    logic              second_valid, second_ready;

    logic signed [brc_pkg::TOUT_W-1:0] temperature_centi;
    logic [brc_pkg::POUT_W-1:0]        pressure_centi_mbar;
    logic                              out_of_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cal_reg <= '0;
        else if (cfg_we)
        begin
            unique case (brc_pkg::cfg_idx_t'(cfg_index))
                brc_pkg::CFG_C1: cal_reg.c1 <= cfg_data;
                brc_pkg::CFG_C2: cal_reg.c2 <= cfg_data;
                brc_pkg::CFG_C3: cal_reg.c3 <= cfg_data;
                brc_pkg::CFG_C4: cal_reg.c4 <= cfg_data;
                brc_pkg::CFG_C5: cal_reg.c5 <= cfg_data;
                brc_pkg::CFG_C6: cal_reg.c6 <= cfg_data;
                default: ;
            endcase
        end
    end

    brc_first u_first (
        .clk             (clk),
        .rst_n           (rst_n),
        .cal             (cal_reg),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .raw_pressure    (s_tdata[23:0]),
        .raw_temperature (s_tdata[47:24]),
        .out_valid       (first_valid),
        .out_ready       (first_ready),
        .out_word        (first_word)
    );

    brc_second u_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (first_valid),
        .in_ready  (first_ready),
        .in_word   (first_word),
        .out_valid (second_valid),
        .out_ready (second_ready),
        .out_word  (second_word)
    );

    brc_pres u_pres (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (second_valid),
        .in_ready            (second_ready),
        .in_word             (second_word),
        .out_valid           (m_tvalid),
        .out_ready           (m_tready),
        .temperature_centi   (temperature_centi),
        .pressure_centi_mbar (pressure_centi_mbar),
        .out_of_range        (out_of_range)
    );

    assign m_tdata = {pressure_centi_mbar, temperature_centi};
    assign m_tuser = out_of_range;

    // results always inside the saturation window
    a_temp_window: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(temperature_centi) >= -15'sd4000)
                  && ($signed(temperature_centi) <= 15'sd8500))
        else $error("temperature outside saturation window");

    a_pres_window: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pressure_centi_mbar >= 17'd1000) && (pressure_centi_mbar <= 17'd120000))
        else $error("pressure outside saturation window");

    // input backpressure only comes from a stalled, full output stage
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output side can move");

endmodule

/* tb/sv/tb_barometer_reading_compensation_core.sv */
// self-checking testbench for the barometer reading compensation core
`timescale 1ns / 1ps

module tb_barometer_reading_compensation_core;

    localparam int          ITEMS_PER_PHASE = 203;
    localparam int          NUM_PHASES      = 9;
    localparam int          DRAIN_LIMIT     = 20000;
    localparam int          MAX_REPORTS     = 10;
    localparam logic [2:0]  CFG_UNUSED_6    = 3'd6;
    localparam logic [2:0]  CFG_UNUSED_7    = 3'd7;
    localparam logic [23:0] RAW_MAX         = 24'hFFFFFF;

    typedef struct packed {
        logic signed [brc_pkg::TOUT_W-1:0] temp;
        logic [brc_pkg::POUT_W-1:0]        pres;
        logic                              clamped;
    } reading_t;

    class compensation_scoreboard;
        brc_pkg::cal_t cal;
        reading_t      expected_readings[$];
        int            mismatches;

        function new();
            cal = '0;
            mismatches = 0;
        endfunction

        function void set_coeff(logic [2:0] idx, logic [brc_pkg::COEF_W-1:0] v);
            case (idx)
                brc_pkg::CFG_C1: cal.c1 = v;
                brc_pkg::CFG_C2: cal.c2 = v;
                brc_pkg::CFG_C3: cal.c3 = v;
                brc_pkg::CFG_C4: cal.c4 = v;
                brc_pkg::CFG_C5: cal.c5 = v;
                brc_pkg::CFG_C6: cal.c6 = v;
                default: ;
            endcase
        endfunction

        // second-order compensation, all shifts floor on signed 64-bit values
        function reading_t compensate(logic [brc_pkg::RAW_W-1:0] d1,
                                      logic [brc_pkg::RAW_W-1:0] d2);
            longint   dt, temp, off, sens, t2, off2, sens2, sq, p;
            reading_t r;
            dt   = longint'(d2) - longint'(cal.c5) * 256;
            temp = 2000 + ((dt * longint'(cal.c6)) >>> 23);
            off  = longint'(cal.c2) * 131072 + ((longint'(cal.c4) * dt) >>> 6);
            sens = longint'(cal.c1) * 65536 + ((longint'(cal.c3) * dt) >>> 7);
            if (temp < 2000)
            begin
                sq    = (temp - 2000) * (temp - 2000);
                t2    = (3 * dt * dt) >>> 33;
                off2  = (61 * sq) >>> 4;
                sens2 = (29 * sq) >>> 4;
                if (temp < -1500)
                begin
                    sq    = (temp + 1500) * (temp + 1500);
                    off2  = off2 + 17 * sq;
                    sens2 = sens2 + 9 * sq;
                end
            end
            else
            begin
                t2    = (5 * dt * dt) >>> 38;
                off2  = 0;
                sens2 = 0;
            end
            temp = temp - t2;
            off  = off - off2;
            sens = sens - sens2;
            p = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
            r.clamped = 1'b0;
            if (temp < brc_pkg::TEMP_MIN_CENTI)
            begin
                temp      = brc_pkg::TEMP_MIN_CENTI;
                r.clamped = 1'b1;
            end
            if (temp > brc_pkg::TEMP_MAX_CENTI)
            begin
                temp      = brc_pkg::TEMP_MAX_CENTI;
                r.clamped = 1'b1;
            end
            if (p < brc_pkg::PRES_MIN_CENTI)
            begin
                p         = brc_pkg::PRES_MIN_CENTI;
                r.clamped = 1'b1;
            end
            if (p > brc_pkg::PRES_MAX_CENTI)
            begin
                p         = brc_pkg::PRES_MAX_CENTI;
                r.clamped = 1'b1;
            end
            r.temp = temp[brc_pkg::TOUT_W-1:0];
            r.pres = p[brc_pkg::POUT_W-1:0];
            return r;
        endfunction

        function void note_reading(logic [brc_pkg::RAW_W-1:0] d1,
                                   logic [brc_pkg::RAW_W-1:0] d2);
            expected_readings.push_back(compensate(d1, d2));
        endfunction

        function void check_word(logic [31:0] data, logic [0:0] flags);
            reading_t want;
            reading_t got;
            got.temp    = data[brc_pkg::TOUT_W-1:0];
            got.pres    = data[31:brc_pkg::TOUT_W];
            got.clamped = flags[0];
            if (expected_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: temp %0d pres %0d flag %0b",
                             got.temp, got.pres, got.clamped);
                return;
            end
            want = expected_readings.pop_front();
            if (got != want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"mismatch: expected temp %0d pres %0d flag %0b, ",
                              "got temp %0d pres %0d flag %0b"},
                             want.temp, want.pres, want.clamped,
                             got.temp, got.pres, got.clamped);
            end
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;   // raw_pressure[23:0], raw_temperature[47:24]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // temperature_centi[14:0], pressure_centi_mbar[31:15]
    logic [0:0]  m_tuser;          // out_of_range[0]
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    int src_idle_pct  = 31;
    int sink_idle_pct = 57;

    compensation_scoreboard sb = new();

    barometer_reading_compensation_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata, m_tuser);
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_word(input logic [23:0] p, input logic [23:0] t);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t, p};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_reading(p, t);
    endtask

    task automatic write_coeff(input logic [2:0] idx, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.set_coeff(idx, v);
    endtask

    task automatic load_calibration(input int phase);
        logic [15:0] w [6];
        logic [2:0]  spare_idx;
        case (phase)
            1:       w = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
            2:       w = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            3, 6:    foreach (w[i]) w[i] = 16'($urandom_range(16'hFFFF));
            4:       w = '{16'd46372, 16'd43981, 16'd29059, 16'd27842,
                           16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF))};
            5:       w = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                           16'($urandom_range(16'hFFFF)), 16'hFFFF};
            8:       w = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000};
            default: w = '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165};
        endcase
        write_coeff(brc_pkg::CFG_C1, w[0]);
        write_coeff(brc_pkg::CFG_C2, w[1]);
        write_coeff(brc_pkg::CFG_C3, w[2]);
        write_coeff(brc_pkg::CFG_C4, w[3]);
        write_coeff(brc_pkg::CFG_C5, w[4]);
        write_coeff(brc_pkg::CFG_C6, w[5]);
        // writes to the unused indexes must leave the calibration alone
        if (phase % 2 == 1)
        begin
            spare_idx = (phase % 4 == 1) ? CFG_UNUSED_6 : CFG_UNUSED_7;
            write_coeff(spare_idx, 16'($urandom_range(16'hFFFF)));
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_reading();
        logic [23:0] p;
        logic [23:0] t;
        longint      centre;
        int          kind;
        kind   = $urandom_range(9);
        centre = longint'(sb.cal.c5) * 256 + int'($urandom_range(4_000_000)) - 2_500_000;
        if (centre < 0)
            centre = 0;
        if (centre > longint'(RAW_MAX))
            centre = longint'(RAW_MAX);
        if (kind < 6)
        begin
            // plausible readings around the reference temperature
            p = 24'($urandom_range(12_000_000, 3_000_000));
            t = centre[23:0];
        end
        else if (kind < 9)
        begin
            p = 24'($urandom);
            t = 24'($urandom);
        end
        else
        begin
            p = $urandom_range(1) ? RAW_MAX : 24'h000000;
            t = $urandom_range(1) ? (24'h1 << $urandom_range(23))
                                  : ~(24'h1 << $urandom_range(23));
        end
        send_word(p, t);
    endtask

    task automatic wait_for_drain();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [23:0] dir_temp [8];
        logic [23:0] dir_pres [3];
        int          n;
        // cold clamp, very-low edges, low/high edge at the reference, warm, hot clamp
        dir_temp = '{24'd0, 24'd7035134, 24'd7035135, 24'd8077567, 24'd8077568,
                     24'd8400000, 24'd9000000, RAW_MAX};
        dir_pres = '{24'd0, 24'd6465444, RAW_MAX};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // calibration still at its reset value
        send_word(24'd6465444, 24'd8077636);
        s_tvalid <= 1'b0;
        wait_for_drain();

        load_calibration(0);
        foreach (dir_temp[i])
            foreach (dir_pres[j])
                send_word(dir_pres[j], dir_temp[i]);
        s_tvalid <= 1'b0;

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                wait_for_drain();
                load_calibration(phase);
            end
            case (phase / 3)
                0:
                begin
                    src_idle_pct  = 31;
                    sink_idle_pct = 57;
                end
                1:
                begin
                    src_idle_pct  = 57;
                    sink_idle_pct = 31;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            repeat (ITEMS_PER_PHASE)
                send_random_reading();
            s_tvalid <= 1'b0;
        end

        n = 0;
        while (n < DRAIN_LIMIT && sb.pending() != 0)
        begin
            @(posedge clk);
            n++;
        end
        repeat (16) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
